// ===== rtl/core/dqr_pkg.sv =====
package dqr_pkg;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_REVERSE    = 3'd4,
      CMD_CLEAR      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic exec;
      logic rd;
      logic load;
   } ctl_type;

   localparam int CMD_BITS   = 3;
   localparam int COUNT_BITS = 5;

endpackage

// ===== rtl/core/dqr_ctrl.sv =====
module dqr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output dqr_pkg::ctl_type ctl
);

   dqr_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dqr_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ctl        = '0;
      unique case (state_ff)
         dqr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.exec = 1'b1;
               state_in = dqr_pkg::S_READ;
            end
         end
         dqr_pkg::S_READ: begin
            ctl.rd   = 1'b1;
            state_in = dqr_pkg::S_LOAD;
         end
         dqr_pkg::S_LOAD: begin
            if (!out_valid_ff || rsp_tready) begin
               ctl.load = 1'b1;
               state_in = dqr_pkg::S_IDLE;
            end
         end
         default: state_in = dqr_pkg::S_IDLE;
      endcase

      priority if (ctl.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

// ===== rtl/core/dqr_datapath.sv =====
module dqr_datapath #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 64,
   parameter int AW        = $clog2(DEPTH),
   parameter int CW        = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dqr_pkg::ctl_type       ctl,
   input  dqr_pkg::cmd_type       command,
   input  logic [WORD_BITS-1:0]   word_in,
   output logic [WORD_BITS-1:0]   front_word,
   output logic [WORD_BITS-1:0]   back_word,
   output logic [CW-1:0]          entry_count,
   output logic                   is_empty,
   output dqr_pkg::status_type    status,
   output logic [CW-1:0]          live_count
);

   localparam int SW = AW + 1;

   logic [WORD_BITS-1:0] ring_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_low_ff, rd_high_ff;

   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rev_ff, rev_in;
   dqr_pkg::status_type  status_ff, status_in;

   logic [WORD_BITS-1:0] front_ff, front_in, back_ff, back_in;
   logic [CW-1:0]        ecount_ff;
   logic                 empty_ff;
   dqr_pkg::status_type  ostatus_ff;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        head_dec, head_inc, slot_next, slot_last;
   logic [SW-1:0]        sum_next, sum_last;
   logic                 to_low;

   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   assign sum_next  = SW'(head_ff) + SW'(count_ff);
   assign slot_next = (sum_next >= SW'(DEPTH)) ? AW'(sum_next - SW'(DEPTH)) : AW'(sum_next);
   assign sum_last  = SW'(head_ff) + SW'(count_ff - CW'(1));
   assign slot_last = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      rev_in    = rev_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = slot_next;
      to_low    = 1'b0;
      if (ctl.exec) begin
         status_in = dqr_pkg::ST_OK;
         unique case (command)
            dqr_pkg::CMD_PUSH_FRONT, dqr_pkg::CMD_PUSH_BACK: begin
               to_low = (command == dqr_pkg::CMD_PUSH_FRONT) != rev_ff;
               if (count_ff == CW'(DEPTH)) begin
                  status_in = dqr_pkg::ST_OVERFLOW;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (to_low) begin
                     head_in = head_dec;
                     wr_addr = head_dec;
                  end
               end
            end
            dqr_pkg::CMD_POP_FRONT, dqr_pkg::CMD_POP_BACK: begin
               to_low = (command == dqr_pkg::CMD_POP_FRONT) != rev_ff;
               if (count_ff == '0) begin
                  status_in = dqr_pkg::ST_UNDERFLOW;
               end else begin
                  count_in = count_ff - CW'(1);
                  if (to_low) begin
                     head_in = head_inc;
                  end
               end
            end
            dqr_pkg::CMD_REVERSE: begin
               if (count_ff == '0) begin
                  status_in = dqr_pkg::ST_UNDERFLOW;
               end else begin
                  rev_in = !rev_ff;
               end
            end
            dqr_pkg::CMD_CLEAR: begin
               head_in  = '0;
               count_in = '0;
               rev_in   = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // ring store, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= word_in;
      end
      if (ctl.rd) begin
         rd_low_ff  <= ring_ff[head_ff];
         rd_high_ff <= ring_ff[slot_last];
      end
   end

   always_comb begin
      front_in = '0;
      back_in  = '0;
      if (count_ff != '0) begin
         front_in = rev_ff ? rd_high_ff : rd_low_ff;
         back_in  = rev_ff ? rd_low_ff : rd_high_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         front_ff   <= front_in;
         back_ff    <= back_in;
         ecount_ff  <= count_ff;
         empty_ff   <= (count_ff == '0);
         ostatus_ff <= status_ff;
      end
   end

   assign front_word  = front_ff;
   assign back_word   = back_ff;
   assign entry_count = ecount_ff;
   assign is_empty    = empty_ff;
   assign status      = ostatus_ff;
   assign live_count  = count_ff;

endmodule

// ===== rtl/core/double_ended_queue_with_reverse.sv =====
// channel   dir  ports                      content
// req       in   req_tvalid/tready/tdata    word_in; tuser command
// rsp       out  rsp_tvalid/tready/tdata    front, back, count, empty, status
//
// Each item passes three steps: command and ring write, registered ring read,
// load of the output register. A new item is taken only once the last one is
// loaded, as the registered read port of the ring store follows the write.
// Reset clears pointers, count and direction; the ring store holds no reset.
// A stalled result holds the block in its load step until the output is taken.
module double_ended_queue_with_reverse #(
   parameter int DEPTH     = 16,
   parameter int WORD_BITS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,  // [63:0] word_in
   input  logic [2:0]   req_tuser,  // [2:0] command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata   // [63:0] front_word, [127:64] back_word,
                                    // [132:128] entry_count, [133] is_empty,
                                    // [135:134] status
);

   localparam int CW = $clog2(DEPTH + 1);

   dqr_pkg::ctl_type     ctl;
   logic [WORD_BITS-1:0] front_word, back_word;
   logic [CW-1:0]        entry_count, live_count;
   logic                 is_empty;
   dqr_pkg::status_type  status;

   dqr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   dqr_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .command     (dqr_pkg::cmd_type'(req_tuser[dqr_pkg::CMD_BITS-1:0])),
      .word_in     (req_tdata[WORD_BITS-1:0]),
      .front_word  (front_word),
      .back_word   (back_word),
      .entry_count (entry_count),
      .is_empty    (is_empty),
      .status      (status),
      .live_count  (live_count)
   );

   assign rsp_tdata = {status, is_empty, dqr_pkg::COUNT_BITS'(entry_count),
                       64'(back_word), 64'(front_word)};

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      live_count <= CW'(DEPTH))
      else $error("count beyond depth");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == dqr_pkg::ST_UNDERFLOW) |-> is_empty)
      else $error("underflow reported on non-empty deque");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status == dqr_pkg::ST_OVERFLOW) |->
         (!is_empty && entry_count == CW'(DEPTH)))
      else $error("overflow reported on non-full deque");

endmodule

// ===== dv/double_ended_queue_with_reverse_test.sv =====
`timescale 1ns / 1ps

module double_ended_queue_with_reverse_test;

   localparam int DEPTH       = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_ITEMS = 640;
   localparam int DRAIN_WAIT  = 12;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   typedef struct {
      logic [2:0]  cmd;
      logic [63:0] word;
   } deque_req_type;

   typedef struct {
      logic [63:0]         front;
      logic [63:0]         back;
      logic [4:0]          count;
      logic                empty;
      dqr_pkg::status_type status;
   } deque_view_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;  // [63:0] word_in
   logic [2:0]   req_tuser = '0;  // [2:0] command
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;       // [63:0] front_word, [127:64] back_word,
                                  // [132:128] entry_count, [133] is_empty,
                                  // [135:134] status

   deque_req_type  pending_items[$];
   deque_view_type expected_views[$];

   logic [63:0] shadow_ring [DEPTH];
   logic [3:0]  shadow_head = '0;
   logic [4:0]  shadow_count = '0;
   logic        shadow_rev = 1'b0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   logic hold_start = 1'b0;
   int stall_cycles = 0;
   int error_count = 0;

   double_ended_queue_with_reverse dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic deque_view_type apply_command(logic [2:0] cmd, logic [63:0] word);
      deque_view_type v;
      logic [3:0]  slot;
      logic [63:0] low_w;
      logic [63:0] high_w;
      v.status = dqr_pkg::ST_OK;
      low_w = '0;
      high_w = '0;
      case (cmd)
         dqr_pkg::CMD_PUSH_FRONT, dqr_pkg::CMD_PUSH_BACK: begin
            if (shadow_count == DEPTH) begin
               v.status = dqr_pkg::ST_OVERFLOW;
            end else if ((cmd == dqr_pkg::CMD_PUSH_FRONT) != shadow_rev) begin
               shadow_head = shadow_head - 4'd1;
               shadow_ring[shadow_head] = word;
               shadow_count = shadow_count + 5'd1;
            end else begin
               slot = shadow_head + shadow_count[3:0];
               shadow_ring[slot] = word;
               shadow_count = shadow_count + 5'd1;
            end
         end
         dqr_pkg::CMD_POP_FRONT, dqr_pkg::CMD_POP_BACK: begin
            if (shadow_count == 0) begin
               v.status = dqr_pkg::ST_UNDERFLOW;
            end else if ((cmd == dqr_pkg::CMD_POP_FRONT) != shadow_rev) begin
               shadow_head = shadow_head + 4'd1;
               shadow_count = shadow_count - 5'd1;
            end else begin
               shadow_count = shadow_count - 5'd1;
            end
         end
         dqr_pkg::CMD_REVERSE: begin
            if (shadow_count == 0) v.status = dqr_pkg::ST_UNDERFLOW;
            else shadow_rev = ~shadow_rev;
         end
         dqr_pkg::CMD_CLEAR: begin
            shadow_head = '0;
            shadow_count = '0;
            shadow_rev = 1'b0;
         end
         default: ;
      endcase
      if (shadow_count != 0) begin
         slot = shadow_head + shadow_count[3:0] - 4'd1;
         low_w = shadow_ring[shadow_head];
         high_w = shadow_ring[slot];
      end
      v.front = shadow_rev ? high_w : low_w;
      v.back  = shadow_rev ? low_w : high_w;
      v.count = shadow_count;
      v.empty = (shadow_count == 0);
      return v;
   endfunction

   function automatic logic [63:0] rand_word();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic queue_item(logic [2:0] cmd, logic [63:0] word);
      deque_req_type it;
      it.cmd = cmd;
      it.word = word;
      pending_items.push_back(it);
   endtask

   task automatic queue_random(int n);
      int made;
      int run_len;
      int push_pct;
      int r;
      int k;
      made = 0;
      while (made < n) begin
         run_len = $urandom_range(60, 20);
         case ($urandom_range(2))
            0: push_pct = 75;
            1: push_pct = 25;
            default: push_pct = 50;
         endcase
         for (k = 0; k < run_len && made < n; k++) begin
            r = $urandom_range(99);
            if (r < 1) queue_item(($urandom_range(1) != 0) ? CMD_SPARE_7 : CMD_SPARE_6,
                                  rand_word());
            else if (r < 2) queue_item(dqr_pkg::CMD_CLEAR, rand_word());
            else if (r < 8) queue_item(dqr_pkg::CMD_REVERSE, rand_word());
            else if ($urandom_range(99) < push_pct)
               queue_item(($urandom_range(1) != 0) ? dqr_pkg::CMD_PUSH_BACK
                                                   : dqr_pkg::CMD_PUSH_FRONT,
                          rand_word());
            else
               queue_item(($urandom_range(1) != 0) ? dqr_pkg::CMD_POP_BACK
                                                   : dqr_pkg::CMD_POP_FRONT,
                          rand_word());
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || req_tvalid || expected_views.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_views.push_back(apply_command(req_tuser, req_tdata));
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_items[0].cmd;
               req_tdata  <= pending_items[0].word;
               void'(pending_items.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_start) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // monitor
   always @(posedge clock) begin
      deque_view_type exp_v;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_views.size() == 0) begin
               $error("unexpected item on rsp: %h", rsp_tdata);
               error_count++;
            end else begin
               exp_v = expected_views.pop_front();
               if (rsp_tdata[63:0] !== exp_v.front) begin
                  $error("front_word: expected %h, got %h", exp_v.front, rsp_tdata[63:0]);
                  error_count++;
               end
               if (rsp_tdata[127:64] !== exp_v.back) begin
                  $error("back_word: expected %h, got %h", exp_v.back, rsp_tdata[127:64]);
                  error_count++;
               end
               if (rsp_tdata[132:128] !== exp_v.count) begin
                  $error("entry_count: expected %0d, got %0d", exp_v.count,
                         rsp_tdata[132:128]);
                  error_count++;
               end
               if (rsp_tdata[133] !== exp_v.empty) begin
                  $error("is_empty: expected %b, got %b", exp_v.empty, rsp_tdata[133]);
                  error_count++;
               end
               if (rsp_tdata[135:134] !== exp_v.status) begin
                  $error("status: expected %0d, got %0d", exp_v.status, rsp_tdata[135:134]);
                  error_count++;
               end
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 15;
      recv_idle_pct = 47;

      // empty deque: pops and reverse underflow, then pushes, pops, spare commands and clears
      queue_item(dqr_pkg::CMD_POP_FRONT, '1);
      queue_item(dqr_pkg::CMD_POP_BACK, '0);
      queue_item(dqr_pkg::CMD_REVERSE, '1);
      queue_item(dqr_pkg::CMD_PUSH_FRONT, '0);
      queue_item(dqr_pkg::CMD_PUSH_BACK, '1);
      queue_item(dqr_pkg::CMD_PUSH_FRONT, 64'hA5A5_5A5A_F00F_0FF0);
      queue_item(dqr_pkg::CMD_REVERSE, '0);
      queue_item(dqr_pkg::CMD_PUSH_FRONT, 64'h0123_4567_89AB_CDEF);
      queue_item(dqr_pkg::CMD_PUSH_BACK, 64'h8000_0000_0000_0001);
      queue_item(dqr_pkg::CMD_POP_FRONT, '0);
      queue_item(dqr_pkg::CMD_POP_BACK, '0);
      queue_item(CMD_SPARE_6, '1);
      queue_item(CMD_SPARE_7, '1);
      queue_item(dqr_pkg::CMD_REVERSE, '0);
      queue_item(dqr_pkg::CMD_POP_BACK, '0);
      queue_item(dqr_pkg::CMD_CLEAR, '1);
      queue_item(dqr_pkg::CMD_POP_FRONT, '0);
      queue_item(dqr_pkg::CMD_PUSH_BACK, 64'h1);
      queue_item(dqr_pkg::CMD_REVERSE, '0);
      queue_item(dqr_pkg::CMD_CLEAR, '0);
      queue_item(dqr_pkg::CMD_CLEAR, '0);
      wait_drained();

      // receiver holds off while the sender keeps going
      queue_random(PHASE_ITEMS);
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      wait_drained();

      send_idle_pct = 47;
      recv_idle_pct = 15;
      queue_random(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(PHASE_ITEMS);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_views.size() != 0) begin
         $error("%0d expected items never arrived", expected_views.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
